/* rtl/tspp_pkg.sv */
// ----------------------------------------------------------------------------
// tspp_pkg: shared types and constants of the TS packet header parser
// Sync constants, result codes, the lock mode type and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package tspp_pkg;

	// transport stream framing
	localparam logic [7:0] SYNC_BYTE  = 8'h47;
	localparam int         CORE_BYTES = 188;
	localparam logic [7:0] ADAPT_MAX  = 8'(CORE_BYTES - 5);
	localparam int         PCR_MULT   = 300;
	localparam int         PCR_W      = 42;

	// result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// output bus width: all fields but kind and last, padded to bytes
	localparam int FIELD_BITS = 13 + 1 + 1 + 2 + 2 + 4 + 1 + PCR_W + 8;
	localparam int OUT_DATA_W = ((FIELD_BITS + 7) / 8) * 8;

	// sync acquisition mode
	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_CAND,
		MODE_LOCK
	} tspp_mode_t;

	// one result word
	typedef struct packed {
		logic             kind;
		logic [12:0]      pid;
		logic             unit_start;
		logic             tei;
		logic [1:0]       scramble;
		logic [1:0]       adapt;
		logic [3:0]       cc;
		logic             pcr_present;
		logic [PCR_W-1:0] pcr_value;
		logic [7:0]       payload_byte;
		logic             last;
	} tspp_result_t;

endpackage

`default_nettype wire

/* rtl/tspp_core.sv */
// ----------------------------------------------------------------------------
// tspp_core: sync tracking and header field extraction
// Consumes one stream byte per step, keeps lock and packet position state and
// forms the result word the byte produces, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module tspp_core #(
	parameter int PACKET_BYTES = 188
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            byte_in,
	output logic                       res_valid,
	output tspp_pkg::tspp_result_t     res
);
	import tspp_pkg::*;

	localparam int POS_W = $clog2(PACKET_BYTES + 1);

	tspp_mode_t       mode_q, mode_d;
	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	logic [23:0]      hdr_q, hdr_d;
	logic [7:0]       arem_q, arem_d;
	logic [39:0]      pcr_q, pcr_d;
	logic             pflag_q, pflag_d;
	logic [1:0]       ac;
	logic [32:0]      pcr_base;
	logic [8:0]       pcr_ext;
	logic [PCR_W-1:0] pcr_ticks;

	// clock reference from five held bytes plus the current one
	assign pcr_base  = pcr_q[39:7];
	assign pcr_ext   = {pcr_q[0], byte_in};
	assign pcr_ticks = ({9'b0, pcr_base} * PCR_W'(PCR_MULT)) + PCR_W'(pcr_ext);

	assign ac      = hdr_q[5:4];
	assign pos_inc = (pos_q == POS_W'(PACKET_BYTES - 1)) ? '0 : pos_q + 1'b1;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			pos_q   <= '0;
			hdr_q   <= '0;
			arem_q  <= '0;
			pcr_q   <= '0;
			pflag_q <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			hdr_q   <= hdr_d;
			arem_q  <= arem_d;
			pcr_q   <= pcr_d;
			pflag_q <= pflag_d;
		end
	end

	// next state and result
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		hdr_d   = hdr_q;
		arem_d  = arem_q;
		pcr_d   = pcr_q;
		pflag_d = pflag_q;

		res_valid        = 1'b0;
		res.kind         = KIND_HEADER;
		res.pcr_present  = 1'b0;
		res.pcr_value    = '0;
		res.payload_byte = '0;
		res.last         = 1'b0;

		unique case (mode_q)
			MODE_HUNT: begin
				if (byte_in == SYNC_BYTE) begin
					mode_d = MODE_CAND;
					pos_d  = POS_W'(1);
				end
			end
			MODE_CAND: begin
				if (pos_q < POS_W'(PACKET_BYTES)) begin
					pos_d = pos_q + 1'b1;
				end else if (byte_in == SYNC_BYTE) begin
					mode_d  = MODE_LOCK;
					pos_d   = POS_W'(1);
					hdr_d   = '0;
					arem_d  = '0;
					pflag_d = 1'b0;
				end else begin
					mode_d = MODE_HUNT;
					pos_d  = '0;
				end
			end
			MODE_LOCK: begin
				pos_d = pos_inc;
				if (pos_q == '0) begin
					// sync position
					if (byte_in != SYNC_BYTE) begin
						mode_d = MODE_HUNT;
						pos_d  = '0;
					end
				end else if (pos_q <= POS_W'(3)) begin
					// header bytes 1..3
					hdr_d = {hdr_q[15:0], byte_in};
					if (pos_q == POS_W'(3)) begin
						arem_d  = '0;
						pflag_d = 1'b0;
						if (!byte_in[5]) begin
							res_valid = 1'b1;
						end
					end
				end else if (pos_q == POS_W'(4) && ac[1]) begin
					// adaptation field length
					arem_d  = (byte_in > ADAPT_MAX) ? ADAPT_MAX : byte_in;
					pflag_d = 1'b0;
					if (byte_in == '0) begin
						res_valid = 1'b1;
					end
				end else if (ac[1] && arem_q != '0 && pos_q >= POS_W'(5)) begin
					// adaptation field body
					if (pos_q == POS_W'(5)) begin
						if (byte_in[4] && arem_q >= 8'd7) begin
							pflag_d = 1'b1;
							pcr_d   = '0;
						end else begin
							res_valid = 1'b1;
						end
					end else if (pflag_q && pos_q <= POS_W'(11)) begin
						pcr_d = {pcr_q[31:0], byte_in};
						if (pos_q == POS_W'(11)) begin
							res_valid       = 1'b1;
							res.pcr_present = 1'b1;
							res.pcr_value   = pcr_ticks;
						end
					end
					arem_d = arem_q - 1'b1;
				end else if (ac[0] && pos_q >= POS_W'(4) && pos_q < POS_W'(CORE_BYTES)) begin
					// payload byte
					res_valid        = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = byte_in;
					res.last         = (pos_q == POS_W'(CORE_BYTES - 1));
				end
			end
			default: begin
				mode_d = MODE_HUNT;
				pos_d  = '0;
			end
		endcase

		// header fields from the latched (or just completed) header
		res.pid        = {hdr_d[20:16], hdr_d[15:8]};
		res.unit_start = hdr_d[22];
		res.tei        = hdr_d[23];
		res.scramble   = hdr_d[7:6];
		res.adapt      = hdr_d[5:4];
		res.cc         = hdr_d[3:0];
	end

endmodule

`default_nettype wire

/* rtl/ts_packet_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// ts_packet_header_parser_unit: MPEG-2 transport stream header parser
// Finds packet sync, then emits one header word per packet and one word per
// payload byte.
// ----------------------------------------------------------------------------
// Input stream: one transport stream byte per word on s_axis. Output stream:
// m_axis_tuser says header (0) or payload (1); tlast marks the final payload
// byte of a packet. Header words carry PID, flags, continuity counter and,
// when the adaptation field holds one, the clock reference in 27 MHz ticks.
// Two register stages: a byte is held in the input register, then parsed
// into the result register, from which its result is offered on m_axis.
// One byte per cycle is sustained while m_axis does not stall; bytes that
// yield no result (sync, hunting, adaptation bytes) still take a parse step.
// Lock needs a 0x47 followed by another 0x47 PACKET_BYTES later; the bytes of
// that first candidate packet give no output.
// Reset puts the block in the hunting state with both registers empty.
// When the receiver stalls, the result register holds its word; the input
// register absorbs one more byte, after which s_axis_tready drops until the
// result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_packet_header_parser_unit #(
	parameter int PACKET_BYTES = 188
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // stream_byte
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// packet_pid, unit_start, transport_error, scramble_bits, adapt_control,
	// cont_count, pcr_present, pcr_value, payload_byte, zero pad
	output logic [tspp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [0:0]                           m_axis_tuser,  // result_kind
	output logic                                 m_axis_tlast   // payload_last
);
	import tspp_pkg::*;

	logic         in_valid_s1;
	logic [7:0]   in_byte_s1;
	logic         res_valid_s2;
	tspp_result_t res_s2;
	logic         step;
	logic         core_valid;
	tspp_result_t core_res;

	// parse one held byte whenever the result register can take its output
	assign step          = in_valid_s1 && (!res_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	tspp_core #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_in  (in_byte_s1),
		.res_valid(core_valid),
		.res      (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (step) begin
			res_valid_s2 <= core_valid;
		end else if (m_axis_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			res_s2 <= core_res;
		end
	end

	// output packing
	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.last;
	assign m_axis_tdata  = {
		(OUT_DATA_W - FIELD_BITS)'(0),
		res_s2.payload_byte,
		res_s2.pcr_value,
		res_s2.pcr_present,
		res_s2.cc,
		res_s2.adapt,
		res_s2.scramble,
		res_s2.tei,
		res_s2.unit_start,
		res_s2.pid
	};

	// input side only backs up behind a stalled result
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	// last marker only on payload words
	a_last_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] == KIND_PAYLOAD))
		else $error("tlast on a header word");

	// payload words never carry a clock reference
	a_no_pcr_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] == KIND_PAYLOAD) |-> !res_s2.pcr_present)
		else $error("clock reference on a payload word");

	// clock reference needs an adaptation field
	a_pcr_needs_adapt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.pcr_present) |-> res_s2.adapt[1])
		else $error("clock reference without adaptation field");

endmodule

`default_nettype wire
